>>> sv/gcb_pkg.sv
// Shared constants, the cell descriptor type and the 5x7 font table of the glyph cell blitter.
// Used by the interfaces, the front, the queue, the back and the top level.
package gcb_pkg;

  localparam int BYTES_PER_LINE = 61;
  localparam int TEXT_COLUMNS = 89;
  localparam int TEXT_ROWS = 36;

  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int FIRST_CODE = 32;
  localparam int LAST_CODE = 125;
  localparam logic [7:0] ROW_MASK = 8'hF8;

  localparam int ADDR_W = 16;
  localparam logic [ADDR_W-1:0] ORIGIN_RESET = 16'd16692;

  localparam int COL_W = $clog2(TEXT_COLUMNS);
  localparam int ROWN_W = $clog2(TEXT_ROWS);
  localparam int BITPOS_W = $clog2(TEXT_COLUMNS * GLYPH_W);
  localparam int ROWIDX_W = $clog2(GLYPH_H);
  localparam int LINE_STEP = GLYPH_H * BYTES_PER_LINE;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [GLYPH_W-1:0] glyph_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [2:0] off;
    logic two;
    logic toggle;
    logic [GLYPH_H-1:0][GLYPH_W-1:0] rows;
  } desc_t;

  // Seven bytes per glyph, top row in the most significant byte.
  function automatic logic [GLYPH_H*8-1:0] glyph_bytes(input logic [6:0] idx);
    logic [GLYPH_H*8-1:0] g;
    case (idx)
      7'd0: g = 56'h00000000000000;
      7'd1: g = 56'h20202020002000;
      7'd2: g = 56'h50505000000000;
      7'd3: g = 56'h0050F850F85000;
      7'd4: g = 56'h0070A070287000;
      7'd5: g = 56'h80902040901000;
      7'd6: g = 56'h0040A040A05000;
      7'd7: g = 56'h20202000000000;
      7'd8: g = 56'h20404040402000;
      7'd9: g = 56'h40202020204000;
      7'd10: g = 56'h00502070205000;
      7'd11: g = 56'h002020F8202000;
      7'd12: g = 56'h00000000302000;
      7'd13: g = 56'h000000F0000000;
      7'd14: g = 56'h00000000606000;
      7'd15: g = 56'h00102040800000;
      7'd16: g = 56'h20505050502000;
      7'd17: g = 56'h20602020207000;
      7'd18: g = 56'h6090102040F000;
      7'd19: g = 56'hF0106010906000;
      7'd20: g = 56'h2060A0F0202000;
      7'd21: g = 56'hF080E010906000;
      7'd22: g = 56'h6080E090906000;
      7'd23: g = 56'hF0102020404000;
      7'd24: g = 56'h60906090906000;
      7'd25: g = 56'h60909070106000;
      7'd26: g = 56'h00606000606000;
      7'd27: g = 56'h00606000604000;
      7'd28: g = 56'h00102040201000;
      7'd29: g = 56'h0000F000F00000;
      7'd30: g = 56'h00402010204000;
      7'd31: g = 56'h20501020002000;
      7'd32: g = 56'h6090B0B0806000;
      7'd33: g = 56'h609090F0909000;
      7'd34: g = 56'hE090E09090E000;
      7'd35: g = 56'h60908080906000;
      7'd36: g = 56'hE090909090E000;
      7'd37: g = 56'hF080E08080F000;
      7'd38: g = 56'hF080E080808000;
      7'd39: g = 56'h609080B0907000;
      7'd40: g = 56'h9090F090909000;
      7'd41: g = 56'h70202020207000;
      7'd42: g = 56'h10101010906000;
      7'd43: g = 56'h90A0C0C0A09000;
      7'd44: g = 56'h8080808080F000;
      7'd45: g = 56'h90F0F090909000;
      7'd46: g = 56'h90D0D0B0B09000;
      7'd47: g = 56'h60909090906000;
      7'd48: g = 56'hE09090E0808000;
      7'd49: g = 56'h60909090D06000;
      7'd50: g = 56'hE09090E0A09000;
      7'd51: g = 56'h60904020906000;
      7'd52: g = 56'h70202020202000;
      7'd53: g = 56'h90909090906000;
      7'd54: g = 56'h90909090606000;
      7'd55: g = 56'h909090F0F09000;
      7'd56: g = 56'h90906060909000;
      7'd57: g = 56'h50505020202000;
      7'd58: g = 56'hF010204080F000;
      7'd59: g = 56'h70404040407000;
      7'd60: g = 56'h00804020100000;
      7'd61: g = 56'h70101010107000;
      7'd62: g = 56'h20500000000000;
      7'd63: g = 56'h0000000000F000;
      7'd64: g = 56'h40200000000000;
      7'd65: g = 56'h00007090B05000;
      7'd66: g = 56'h8080E09090E000;
      7'd67: g = 56'h00006080806000;
      7'd68: g = 56'h10107090907000;
      7'd69: g = 56'h000060B0C06000;
      7'd70: g = 56'h205040E0404000;
      7'd71: g = 56'h00007090608000;
      7'd72: g = 56'h8080E090909000;
      7'd73: g = 56'h20006020207000;
      7'd74: g = 56'h10001010105000;
      7'd75: g = 56'h8080A0C0A09000;
      7'd76: g = 56'h60202020207000;
      7'd77: g = 56'h0000A0F0909000;
      7'd78: g = 56'h0000E090909000;
      7'd79: g = 56'h00006090906000;
      7'd80: g = 56'h0000E09090E000;
      7'd81: g = 56'h00007090907000;
      7'd82: g = 56'h0000E090808000;
      7'd83: g = 56'h000070C030E000;
      7'd84: g = 56'h4040E040403000;
      7'd85: g = 56'h00009090907000;
      7'd86: g = 56'h00005050502000;
      7'd87: g = 56'h00009090F0F000;
      7'd88: g = 56'h00009060609000;
      7'd89: g = 56'h00009090502000;
      7'd90: g = 56'h0000F02040F000;
      7'd91: g = 56'h10206020201000;
      7'd92: g = 56'h20202020202000;
      7'd93: g = 56'h40203020204000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> sv/gcb_ifs.sv
// Valid/ready channel interfaces of the glyph cell blitter: requests, byte writes, configuration.
// Depends on gcb_pkg for the address width.
interface gcb_req_if;
  logic valid;
  logic ready;
  logic func;
  logic [7:0] char_code;
  logic inverse;
  logic signed [7:0] column;
  logic signed [7:0] row;
  modport source(output valid, func, char_code, inverse, column, row, input ready);
  modport sink(input valid, func, char_code, inverse, column, row, output ready);
endinterface

interface gcb_wr_if;
  logic valid;
  logic ready;
  logic [gcb_pkg::ADDR_W-1:0] byte_address;
  logic [7:0] write_data;
  logic [7:0] bit_mask;
  logic toggle;
  logic last;
  modport source(output valid, byte_address, write_data, bit_mask, toggle, last, input ready);
  modport sink(input valid, byte_address, write_data, bit_mask, toggle, last, output ready);
endinterface

interface gcb_cfg_if;
  logic valid;
  logic ready;
  logic [gcb_pkg::ADDR_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> sv/gcb_front.sv
// Request front end: clamps the cell position, computes address and bit offset, fetches the glyph.
// Depends on gcb_pkg and the request interface in gcb_ifs.
module gcb_front import gcb_pkg::*; (
  gcb_req_if.sink req,
  input  logic [ADDR_W-1:0] origin,
  input  logic              full,
  output logic              push,
  output desc_t             desc
);

  logic [COL_W-1:0] x;
  logic [ROWN_W-1:0] y;
  logic [BITPOS_W-1:0] bitpos;
  logic [ADDR_W-1:0] line_off;
  logic code_ok;
  logic [6:0] idx;
  logic [GLYPH_H*8-1:0] gbytes;
  glyph_row_t inv_pat;

  assign req.ready = !full;
  assign push = req.valid && !full;

  always_comb begin
    if (req.row[7]) begin
      x = '0;
      y = '0;
    end else if (req.row[6:0] >= 7'(TEXT_ROWS)) begin
      x = COL_W'(TEXT_COLUMNS - 1);
      y = ROWN_W'(TEXT_ROWS - 1);
    end else begin
      y = req.row[ROWN_W-1:0];
      if (req.column[7]) begin
        x = '0;
      end else if (req.column[6:0] >= 7'(TEXT_COLUMNS)) begin
        x = COL_W'(TEXT_COLUMNS - 1);
      end else begin
        x = req.column[COL_W-1:0];
      end
    end
  end

  assign bitpos = BITPOS_W'(x * GLYPH_W);
  assign line_off = ADDR_W'(y * LINE_STEP);

  assign code_ok = (req.char_code >= 8'(FIRST_CODE)) && (req.char_code <= 8'(LAST_CODE));
  assign idx = code_ok ? 7'(req.char_code - 8'(FIRST_CODE)) : 7'd0;
  assign gbytes = glyph_bytes(idx);
  assign inv_pat = req.inverse ? ROW_MASK[7:8-GLYPH_W] : '0;

  always_comb begin
    desc.base = origin + ADDR_W'(bitpos[BITPOS_W-1:3]) + line_off;
    desc.off = bitpos[2:0];
    desc.two = bitpos[2:0] > 3'(8 - GLYPH_W);
    desc.toggle = req.func;
    for (int r = 0; r < GLYPH_H; r++) begin
      if (req.func) begin
        desc.rows[r] = ROW_MASK[7:8-GLYPH_W];
      end else begin
        desc.rows[r] = gbytes[(GLYPH_H-1-r)*8+7 -: GLYPH_W] ^ inv_pat;
      end
    end
  end

endmodule

>>> sv/gcb_queue.sv
// Short descriptor queue that decouples the request front end from the write sequencer.
// Depends on gcb_pkg for the descriptor type and depth.
module gcb_queue import gcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output desc_t data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/gcb_back.sv
// Write sequencer: walks a cell's 7 glyph rows, one masked byte write per cycle unless wr stalls.
// Depends on gcb_pkg and the write interface in gcb_ifs.
module gcb_back import gcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  desc_t q_data,
  output logic  pop,
  gcb_wr_if.source wr
);

  desc_t cur;
  logic busy;
  logic [ROWIDX_W-1:0] row;
  logic second;
  logic [ADDR_W-1:0] addr;

  logic out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [7:0] out_data;
  logic [7:0] out_mask;
  logic out_toggle;
  logic out_last;

  logic adv;
  logic end_row;
  logic last_row;
  logic fin;
  glyph_row_t g;
  logic [15:0] data_wide;
  logic [15:0] mask_wide;

  assign adv = busy && (!out_valid || wr.ready);
  assign end_row = !cur.two || second;
  assign last_row = row == ROWIDX_W'(GLYPH_H - 1);
  assign fin = adv && end_row && last_row;
  assign pop = q_valid && (!busy || fin);

  assign g = cur.rows[row];
  assign data_wide = {g, {(16 - GLYPH_W){1'b0}}} >> cur.off;
  assign mask_wide = {ROW_MASK, 8'h00} >> cur.off;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (wr.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
      row <= '0;
      second <= 1'b0;
      addr <= q_data.base;
    end else if (adv) begin
      if (!end_row) begin
        second <= 1'b1;
      end else begin
        second <= 1'b0;
        row <= row + 1'b1;
        addr <= addr + ADDR_W'(BYTES_PER_LINE);
      end
    end
    if (adv) begin
      out_addr <= second ? addr + 1'b1 : addr;
      out_data <= second ? data_wide[7:0] : data_wide[15:8];
      out_mask <= second ? mask_wide[7:0] : mask_wide[15:8];
      out_toggle <= cur.toggle;
      out_last <= end_row && last_row;
    end
  end

  assign wr.valid = out_valid;
  assign wr.byte_address = out_addr;
  assign wr.write_data = out_data;
  assign wr.bit_mask = out_mask;
  assign wr.toggle = out_toggle;
  assign wr.last = out_last;

endmodule

>>> sv/glyph_cell_blitter_core.sv
// Top level of the glyph cell blitter: origin register, front end, queue and write sequencer.
// Depends on gcb_pkg, gcb_ifs, gcb_front, gcb_queue and gcb_back.
//
// Each transfer on req names one text cell (draw a 5x7 glyph or invert the cell).
// The block answers with byte writes on wr: 7 writes when the cell sits within one byte
// per glyph row, 14 when it straddles two bytes, with last set on the final one.
// A taken request is stored in the queue, loaded into the sequencer's descriptor register,
// and its first write leaves from the output register. The sequencer emits one write per
// cycle unless wr.ready stalls it, and a queued cell follows the last one without a gap.
// The front end takes a request every cycle while the two-entry descriptor queue has room.
// The cfg channel loads the 16-bit text origin; it is always ready and should
// only be written while no cell is in flight.
// Reset empties the queue and the output register and sets the origin to 16692.
// When the receiver holds wr.ready low, the current write stays on the port, the
// sequencer stops, and the queue fills until req.ready falls.
module glyph_cell_blitter_core import gcb_pkg::*; (
  input logic clk,
  input logic rst,
  gcb_req_if.sink req,
  gcb_wr_if.source wr,
  gcb_cfg_if.sink cfg
);

  logic [ADDR_W-1:0] origin;
  logic push;
  logic full;
  logic pop;
  logic q_valid;
  desc_t push_data;
  desc_t q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= ORIGIN_RESET;
    end else if (cfg.valid) begin
      origin <= cfg.data;
    end
  end

  gcb_front u_front (
    .req(req),
    .origin(origin),
    .full(full),
    .push(push),
    .desc(push_data)
  );

  gcb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .valid(q_valid),
    .data(q_data)
  );

  gcb_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .pop(pop),
    .wr(wr)
  );

  a_data_in_mask: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> (wr.write_data & ~wr.bit_mask) == 8'h00)
    else $error("write data outside bit mask");

  a_toggle_full: assert property (@(posedge clk) disable iff (rst)
    wr.valid && wr.toggle |-> wr.write_data == wr.bit_mask)
    else $error("invert write does not cover the whole mask");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> wr.bit_mask != 8'h00)
    else $error("write with empty bit mask");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !wr.valid && !q_valid)
    else $error("output or queue not empty after reset");

endmodule

>>> verif/glyph_cell_blitter_core_test.sv
// Self-checking testbench of glyph_cell_blitter_core: directed cells, then random cells.
// Each accepted cell is expanded into its expected byte writes, which are checked in order.
// Depends on gcb_pkg, gcb_ifs and the glyph cell blitter RTL.
module glyph_cell_blitter_core_test;
  import gcb_pkg::*;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_INVERT = 1'b1;
  localparam int HOLD_CYCLES = 250;
  localparam int CELLS_PER_PHASE = 48;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0] data;
    logic [7:0] mask;
    logic tog;
    logic last;
  } blit_write_t;

  typedef struct packed {
    logic func;
    logic [7:0] code;
    logic inv;
    logic [7:0] col;
    logic [7:0] row;
    logic typed;
    logic [15:0] addr;
    logic [7:0] data;
    logic [7:0] mask;
    logic tog;
  } cell_case_t;

  // 5x7 font, top glyph row in the most significant byte.
  localparam logic [55:0] FONT [94] = '{
    56'h00000000000000, 56'h20202020002000, 56'h50505000000000, 56'h0050F850F85000,
    56'h0070A070287000, 56'h80902040901000, 56'h0040A040A05000, 56'h20202000000000,
    56'h20404040402000, 56'h40202020204000, 56'h00502070205000, 56'h002020F8202000,
    56'h00000000302000, 56'h000000F0000000, 56'h00000000606000, 56'h00102040800000,
    56'h20505050502000, 56'h20602020207000, 56'h6090102040F000, 56'hF0106010906000,
    56'h2060A0F0202000, 56'hF080E010906000, 56'h6080E090906000, 56'hF0102020404000,
    56'h60906090906000, 56'h60909070106000, 56'h00606000606000, 56'h00606000604000,
    56'h00102040201000, 56'h0000F000F00000, 56'h00402010204000, 56'h20501020002000,
    56'h6090B0B0806000, 56'h609090F0909000, 56'hE090E09090E000, 56'h60908080906000,
    56'hE090909090E000, 56'hF080E08080F000, 56'hF080E080808000, 56'h609080B0907000,
    56'h9090F090909000, 56'h70202020207000, 56'h10101010906000, 56'h90A0C0C0A09000,
    56'h8080808080F000, 56'h90F0F090909000, 56'h90D0D0B0B09000, 56'h60909090906000,
    56'hE09090E0808000, 56'h60909090D06000, 56'hE09090E0A09000, 56'h60904020906000,
    56'h70202020202000, 56'h90909090906000, 56'h90909090606000, 56'h909090F0F09000,
    56'h90906060909000, 56'h50505020202000, 56'hF010204080F000, 56'h70404040407000,
    56'h00804020100000, 56'h70101010107000, 56'h20500000000000, 56'h0000000000F000,
    56'h40200000000000, 56'h00007090B05000, 56'h8080E09090E000, 56'h00006080806000,
    56'h10107090907000, 56'h000060B0C06000, 56'h205040E0404000, 56'h00007090608000,
    56'h8080E090909000, 56'h20006020207000, 56'h10001010105000, 56'h8080A0C0A09000,
    56'h60202020207000, 56'h0000A0F0909000, 56'h0000E090909000, 56'h00006090906000,
    56'h0000E09090E000, 56'h00007090907000, 56'h0000E090808000, 56'h000070C030E000,
    56'h4040E040403000, 56'h00009090907000, 56'h00005050502000, 56'h00009090F0F000,
    56'h00009060609000, 56'h00009090502000, 56'h0000F02040F000, 56'h10206020201000,
    56'h20202020202000, 56'h40203020204000
  };

  // Rows with typed set carry the first byte write of the cell at the reset origin.
  localparam cell_case_t DIRECTED [24] = '{
    '{OP_DRAW,   8'd65,  1'b0, 8'h00, 8'h00, 1'b1, 16'd16692, 8'h60, 8'hF8, 1'b0},
    '{OP_DRAW,   8'd0,   1'b0, 8'h00, 8'h00, 1'b1, 16'd16692, 8'h00, 8'hF8, 1'b0},
    '{OP_DRAW,   8'd31,  1'b0, 8'h01, 8'h00, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd125, 1'b0, 8'h02, 8'h00, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd126, 1'b1, 8'h03, 8'h00, 1'b1, 16'd16693, 8'h01, 8'h01, 1'b0},
    '{OP_DRAW,   8'd255, 1'b1, 8'h04, 8'h00, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd127, 1'b0, 8'h05, 8'h00, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd32,  1'b0, 8'h06, 8'h01, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd128, 1'b1, 8'h07, 8'h02, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_INVERT, 8'd0,   1'b0, 8'h00, 8'h00, 1'b1, 16'd16692, 8'hF8, 8'hF8, 1'b1},
    '{OP_INVERT, 8'd255, 1'b1, 8'h07, 8'h00, 1'b1, 16'd16696, 8'h1F, 8'h1F, 1'b1},
    '{OP_DRAW,   8'd66,  1'b0, 8'd50, 8'hFF, 1'b1, 16'd16692, 8'hE0, 8'hF8, 1'b0},
    '{OP_INVERT, 8'd33,  1'b0, 8'h7F, 8'h80, 1'b1, 16'd16692, 8'hF8, 8'hF8, 1'b1},
    '{OP_DRAW,   8'd90,  1'b0, 8'h00, 8'd36, 1'b1, 16'd31692, 8'hF0, 8'hF8, 1'b0},
    '{OP_INVERT, 8'd90,  1'b1, 8'h80, 8'h7F, 1'b1, 16'd31692, 8'hF8, 8'hF8, 1'b1},
    '{OP_DRAW,   8'd125, 1'b1, 8'd88, 8'd35, 1'b1, 16'd31692, 8'hB8, 8'hF8, 1'b0},
    '{OP_DRAW,   8'd97,  1'b0, 8'hFF, 8'h00, 1'b1, 16'd16692, 8'h00, 8'hF8, 1'b0},
    '{OP_INVERT, 8'd40,  1'b0, 8'h80, 8'd5,  1'b1, 16'd18827, 8'hF8, 8'hF8, 1'b1},
    '{OP_DRAW,   8'd33,  1'b0, 8'd89, 8'd10, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd64,  1'b1, 8'h7F, 8'd20, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_INVERT, 8'd70,  1'b1, 8'h00, 8'd35, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd77,  1'b1, 8'd44, 8'd17, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_DRAW,   8'd94,  1'b0, 8'd87, 8'd34, 1'b0, 16'd0, 8'h00, 8'h00, 1'b0},
    '{OP_INVERT, 8'd50,  1'b0, 8'd85, 8'd3,  1'b0, 16'd0, 8'h00, 8'h00, 1'b0}
  };

  logic clk;
  logic rst;
  logic failed;
  logic hold_go;
  logic hold_on;
  int send_idle_pct;
  int recv_idle_pct;
  logic [15:0] text_origin_q;
  blit_write_t pending_writes [$];
  blit_write_t acc_seq [14];
  blit_write_t want;
  int n_acc;

  gcb_req_if req_ch();
  gcb_wr_if wr_ch();
  gcb_cfg_if cfg_ch();

  glyph_cell_blitter_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .wr(wr_ch),
    .cfg(cfg_ch)
  );

  function automatic int blit_cell_writes(input logic func, input logic [7:0] code,
                                          input logic inv, input logic signed [7:0] col,
                                          input logic signed [7:0] row,
                                          input logic [15:0] origin,
                                          output blit_write_t seq [14]);
    int cx;
    int cy;
    int bitpos;
    int gi;
    int n;
    logic [2:0] off;
    logic [15:0] base;
    logic [15:0] addr;
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] g;
    logic [7:0] d1;
    logic [7:0] d2;
    logic split;
    cx = col;
    cy = row;
    if (cy < 0) begin
      cx = 0;
      cy = 0;
    end else if (cy >= TEXT_ROWS) begin
      cx = TEXT_COLUMNS - 1;
      cy = TEXT_ROWS - 1;
    end else if (cx < 0) begin
      cx = 0;
    end else if (cx >= TEXT_COLUMNS) begin
      cx = TEXT_COLUMNS - 1;
    end
    bitpos = cx * GLYPH_W;
    off = bitpos[2:0];
    base = 16'(origin + bitpos / 8 + cy * GLYPH_H * BYTES_PER_LINE);
    split = (off > 3'd3);
    m1 = ROW_MASK >> off;
    m2 = ROW_MASK << (8 - off);
    gi = (code < FIRST_CODE || code > LAST_CODE) ? 0 : code - FIRST_CODE;
    n = 0;
    for (int r = 0; r < GLYPH_H; r++) begin
      addr = 16'(base + r * BYTES_PER_LINE);
      if (func == OP_INVERT) begin
        d1 = m1;
        d2 = m2;
      end else begin
        g = FONT[gi][55 - 8 * r -: 8];
        if (inv) begin
          g = g ^ ROW_MASK;
        end
        d1 = (g >> off) & m1;
        d2 = (g << (8 - off)) & m2;
      end
      seq[n] = '{addr, d1, m1, func, 1'b0};
      n++;
      if (split) begin
        seq[n] = '{16'(addr + 1), d2, m2, func, 1'b0};
        n++;
      end
    end
    seq[n - 1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      text_origin_q <= ORIGIN_RESET;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        n_acc = blit_cell_writes(req_ch.func, req_ch.char_code, req_ch.inverse,
                                 req_ch.column, req_ch.row, text_origin_q, acc_seq);
        for (int k = 0; k < n_acc; k++) begin
          pending_writes.push_back(acc_seq[k]);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        text_origin_q <= cfg_ch.data;
      end
      if (wr_ch.valid && wr_ch.ready) begin
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none, actual address %0h data %0h",
                   $time, wr_ch.byte_address, wr_ch.write_data);
          failed = 1'b1;
        end else begin
          want = pending_writes.pop_front();
          check_field("byte_address", want.addr, wr_ch.byte_address);
          check_field("write_data", want.data, wr_ch.write_data);
          check_field("bit_mask", want.mask, wr_ch.bit_mask);
          check_field("toggle", want.tog, wr_ch.toggle);
          check_field("last", want.last, wr_ch.last);
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    wr_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      wr_ch.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The long receiver stall that lets the queue fill and back-pressure the requests.
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  task automatic offer_cell(input logic func, input logic [7:0] code, input logic inv,
                            input logic [7:0] col, input logic [7:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= func;
    req_ch.char_code <= code;
    req_ch.inverse <= inv;
    req_ch.column <= col;
    req_ch.row <= row;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic load_origin(input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    blit_write_t dir_seq [14];
    cell_case_t dc;
    logic [15:0] origin;
    logic func;
    logic [7:0] code;
    logic inv;
    logic [7:0] col;
    logic [7:0] row;
    int n;
    failed = 1'b0;
    hold_go = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 67;
    req_ch.valid = 1'b0;
    req_ch.func = 1'b0;
    req_ch.char_code = '0;
    req_ch.inverse = 1'b0;
    req_ch.column = '0;
    req_ch.row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      dc = DIRECTED[i];
      if (dc.typed) begin
        n = blit_cell_writes(dc.func, dc.code, dc.inv, dc.col, dc.row, ORIGIN_RESET, dir_seq);
        if ({dir_seq[0].addr, dir_seq[0].data, dir_seq[0].mask, dir_seq[0].tog} !=
            {dc.addr, dc.data, dc.mask, dc.tog}) begin
          $display("%0t: first write of cell %0d expected %h %h %h %b, actual %h %h %h %b",
                   $time, i, dc.addr, dc.data, dc.mask, dc.tog, dir_seq[0].addr,
                   dir_seq[0].data, dir_seq[0].mask, dir_seq[0].tog);
          failed = 1'b1;
        end
      end
      offer_cell(dc.func, dc.code, dc.inv, dc.col, dc.row);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: origin = 16'h0000;
        1: origin = 16'hFFFF;
        2: origin = 16'($urandom_range(65535));
        3: origin = 16'hAAAA;
        4: origin = 16'($urandom_range(65535));
        default: origin = ORIGIN_RESET;
      endcase
      wait_drained();
      load_origin(origin);
      if (p < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1) begin
        hold_go = 1'b1;
      end
      for (int i = 0; i < CELLS_PER_PHASE; i++) begin
        if (p == 3 && i == CELLS_PER_PHASE / 2) begin
          wait_drained();
        end
        func = ($urandom_range(99) < 30) ? OP_INVERT : OP_DRAW;
        if ($urandom_range(99) < 85) begin
          code = 8'($urandom_range(LAST_CODE, FIRST_CODE));
        end else begin
          code = 8'($urandom_range(255));
        end
        inv = 1'($urandom_range(1));
        if ($urandom_range(99) < 80) begin
          col = 8'($urandom_range(TEXT_COLUMNS - 1));
          row = 8'($urandom_range(TEXT_ROWS - 1));
        end else begin
          col = 8'($urandom_range(255));
          row = 8'($urandom_range(255));
        end
        offer_cell(func, code, inv, col, row);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
